### src/msjp_pkg.sv
// Package for the minimum-step jog patcher: coordinate and patch types,
// stream widths and orientation codes.
// Depends on nothing; used by min_step_jog_patcher.
`default_nettype none

package msjp_pkg;

  localparam int COORD_WIDTH = 31;
  localparam int MIN_STEP_W  = 20;
  localparam int BOX_W       = 32;
  localparam int NUM_CORNERS = 3;
  localparam int CORNER_IDX_W = $clog2(NUM_CORNERS);

  // Edge lengths are compared at the wider of a delta magnitude and min_step.
  localparam int LEN_W = (COORD_WIDTH + 1 > MIN_STEP_W) ? COORD_WIDTH + 1 : MIN_STEP_W;

  localparam int IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = 4 * BOX_W;
  localparam int OUT_USER_W = 3;

  localparam logic [1:0] ORIENT_NE = 2'd0;
  localparam logic [1:0] ORIENT_SE = 2'd1;
  localparam logic [1:0] ORIENT_SW = 2'd2;
  localparam logic [1:0] ORIENT_NW = 2'd3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0]   delta_t;
  typedef logic signed [BOX_W-1:0]       box_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  // Three consecutive ring points around one corner.
  typedef struct packed {
    vertex_t p0;
    vertex_t p1;
    vertex_t p2;
    logic    en;
  } corner_t;

  // Edge deltas in both directions, plus the corner's bounding box.
  typedef struct packed {
    delta_t ax;
    delta_t nax;
    delta_t ay;
    delta_t nay;
    delta_t bx;
    delta_t nbx;
    delta_t by;
    delta_t nby;
    coord_t xl;
    coord_t yl;
    coord_t xh;
    coord_t yh;
    logic   en;
  } corner_diff_t;

  typedef struct packed {
    box_t       xl;
    box_t       yl;
    box_t       xh;
    box_t       yh;
    logic       convex;
    logic [1:0] orient;
  } patch_t;

  typedef struct packed {
    logic   hit;
    patch_t patch;
  } corner_res_t;

endpackage

`default_nettype wire

### src/min_step_jog_patcher.sv
// Minimum-step jog patcher top level: vertex window, corner check pipeline
// and a patch output register that replays up to three patches.
// Depends on msjp_pkg.
`default_nettype none

// Vertices of a rectilinear ring stream in on the slave side, one request per
// vertex, with tlast on the ring's final vertex; every right-angle corner of
// axis-aligned edges that are both shorter than min_step yields a patch box on
// the master side, with tlast on the last patch caused by that vertex. A vertex
// is taken every cycle as long as the master side takes each patch at once and
// each vertex causes at most one patch; a ring-end vertex can cause up to three,
// and the patch output register then holds the pipeline while it replays them.
// A vertex passes the corner register and the delta stage before its first patch
// is presented from the patch register. The user must write min_step only while
// the block is idle; the block itself does not enforce it. Zero turns detection off.
module min_step_jog_patcher
  import msjp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [MIN_STEP_W-1:0]   cfg_wdata,     // min_step
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,  // vert_x, vert_y, zero pad
  input  wire logic                    s_axis_tlast,  // ring_end
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [OUT_DATA_W-1:0]        m_axis_tdata,  // patch_xl, patch_yl, patch_xh, patch_yh
  output logic [OUT_USER_W-1:0]        m_axis_tuser,  // is_convex, orientation
  output logic                         m_axis_tlast   // last_patch
);

  function automatic delta_t sub(coord_t a, coord_t b);
    return delta_t'(a) - delta_t'(b);
  endfunction

  function automatic coord_t min3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic corner_res_t judge(corner_diff_t d, logic [MIN_STEP_W-1:0] ms);
    logic ax_z, ax_n, ax_p, ay_z, ay_n, ay_p;
    logic bx_z, bx_n, bx_p, by_z, by_n, by_p;
    logic found;
    logic [LEN_W-1:0] len_a, len_b, ms_w;
    box_t ms_box;
    corner_res_t r;
    ax_z = (d.ax == '0);
    ax_n = d.ax[COORD_WIDTH];
    ax_p = !ax_z && !ax_n;
    ay_z = (d.ay == '0);
    ay_n = d.ay[COORD_WIDTH];
    ay_p = !ay_z && !ay_n;
    bx_z = (d.bx == '0);
    bx_n = d.bx[COORD_WIDTH];
    bx_p = !bx_z && !bx_n;
    by_z = (d.by == '0);
    by_n = d.by[COORD_WIDTH];
    by_p = !by_z && !by_n;

    // A matching corner has axis-aligned edges, so each edge length is the
    // magnitude of its one nonzero delta.
    len_a = ay_z ? (ax_n ? LEN_W'(unsigned'(d.nax)) : LEN_W'(unsigned'(d.ax)))
                 : (ay_n ? LEN_W'(unsigned'(d.nay)) : LEN_W'(unsigned'(d.ay)));
    len_b = by_z ? (bx_n ? LEN_W'(unsigned'(d.nbx)) : LEN_W'(unsigned'(d.bx)))
                 : (by_n ? LEN_W'(unsigned'(d.nby)) : LEN_W'(unsigned'(d.by)));
    ms_w   = LEN_W'(ms);
    ms_box = BOX_W'(ms);

    found = 1'b1;
    r.patch.convex = 1'b0;
    r.patch.orient = ORIENT_NE;
    if (ax_p && ay_z && bx_z && by_n) begin
      r.patch.convex = 1'b1; r.patch.orient = ORIENT_NE;
    end else if (ax_z && ay_n && bx_n && by_z) begin
      r.patch.convex = 1'b1; r.patch.orient = ORIENT_SE;
    end else if (ax_n && ay_z && bx_z && by_p) begin
      r.patch.convex = 1'b1; r.patch.orient = ORIENT_SW;
    end else if (ax_z && ay_p && bx_p && by_z) begin
      r.patch.convex = 1'b1; r.patch.orient = ORIENT_NW;
    end else if (ax_z && ay_n && bx_p && by_z) begin
      r.patch.orient = ORIENT_NE;
    end else if (ax_p && ay_z && bx_z && by_p) begin
      r.patch.orient = ORIENT_NW;
    end else if (ax_z && ay_p && bx_n && by_z) begin
      r.patch.orient = ORIENT_SW;
    end else if (ax_n && ay_z && bx_z && by_n) begin
      r.patch.orient = ORIENT_SE;
    end else begin
      found = 1'b0;
    end

    r.hit = found && d.en && (len_a < ms_w) && (len_b < ms_w);

    r.patch.xl = BOX_W'($signed(d.xl));
    r.patch.yl = BOX_W'($signed(d.yl));
    r.patch.xh = BOX_W'($signed(d.xh));
    r.patch.yh = BOX_W'($signed(d.yh));
    if (r.patch.convex) begin
      if (r.patch.orient == ORIENT_NE || r.patch.orient == ORIENT_NW) begin
        r.patch.yh = r.patch.yh + ms_box;
      end else begin
        r.patch.yl = r.patch.yl - ms_box;
      end
    end
    return r;
  endfunction

  logic [MIN_STEP_W-1:0] min_step;

  // Ring window.
  vertex_t    first_vertex;
  vertex_t    second_vertex;
  vertex_t    older_vertex;
  vertex_t    newer_vertex;
  logic [1:0] vertex_count;

  vertex_t vin;
  logic    s_fire;

  // Pipeline stages.
  logic         a_valid;
  corner_t      a_corner [NUM_CORNERS];
  corner_t      a_corner_next [NUM_CORNERS];
  logic         b_valid;
  corner_diff_t b_diff [NUM_CORNERS];
  corner_diff_t b_diff_next [NUM_CORNERS];
  corner_res_t  c_res [NUM_CORNERS];
  patch_t       g_patch [NUM_CORNERS];
  logic [NUM_CORNERS-1:0] g_mask;
  logic [NUM_CORNERS-1:0] g_sel;
  logic [CORNER_IDX_W-1:0] g_idx;
  logic         g_single;
  logic         g_ready;
  logic         b_free;
  logic         a_free;

  assign vin.x  = s_axis_tdata[COORD_WIDTH-1:0];
  assign vin.y  = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // The patch register takes a new group once it is empty or its last
  // remaining patch leaves this cycle.
  assign g_single = (g_mask != '0) && ((g_mask & (g_mask - 1'b1)) == '0);
  assign g_ready  = (g_mask == '0) || (m_axis_tready && g_single);
  assign b_free   = !b_valid || g_ready;
  assign a_free   = !a_valid || b_free;
  assign s_axis_tready = a_free;

  always_comb begin
    a_corner_next[0].p0 = older_vertex;
    a_corner_next[0].p1 = newer_vertex;
    a_corner_next[0].p2 = vin;
    a_corner_next[0].en = vertex_count[1];
    a_corner_next[1].p0 = newer_vertex;
    a_corner_next[1].p1 = vin;
    a_corner_next[1].p2 = first_vertex;
    a_corner_next[1].en = vertex_count[1] && s_axis_tlast;
    a_corner_next[2].p0 = vin;
    a_corner_next[2].p1 = first_vertex;
    a_corner_next[2].p2 = second_vertex;
    a_corner_next[2].en = vertex_count[1] && s_axis_tlast;
  end

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      b_diff_next[k].ax  = sub(a_corner[k].p1.x, a_corner[k].p0.x);
      b_diff_next[k].nax = sub(a_corner[k].p0.x, a_corner[k].p1.x);
      b_diff_next[k].ay  = sub(a_corner[k].p1.y, a_corner[k].p0.y);
      b_diff_next[k].nay = sub(a_corner[k].p0.y, a_corner[k].p1.y);
      b_diff_next[k].bx  = sub(a_corner[k].p2.x, a_corner[k].p1.x);
      b_diff_next[k].nbx = sub(a_corner[k].p1.x, a_corner[k].p2.x);
      b_diff_next[k].by  = sub(a_corner[k].p2.y, a_corner[k].p1.y);
      b_diff_next[k].nby = sub(a_corner[k].p1.y, a_corner[k].p2.y);
      b_diff_next[k].xl  = min3(a_corner[k].p0.x, a_corner[k].p1.x, a_corner[k].p2.x);
      b_diff_next[k].yl  = min3(a_corner[k].p0.y, a_corner[k].p1.y, a_corner[k].p2.y);
      b_diff_next[k].xh  = max3(a_corner[k].p0.x, a_corner[k].p1.x, a_corner[k].p2.x);
      b_diff_next[k].yh  = max3(a_corner[k].p0.y, a_corner[k].p1.y, a_corner[k].p2.y);
      b_diff_next[k].en  = a_corner[k].en;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      c_res[k] = judge(b_diff[k], min_step);
    end
  end

  // Patches leave in corner order: lowest pending slot first.
  always_comb begin
    g_sel = '0;
    g_idx = '0;
    for (int k = NUM_CORNERS - 1; k >= 0; k--) begin
      if (g_mask[k]) begin
        g_sel = '0;
        g_sel[k] = 1'b1;
        g_idx = CORNER_IDX_W'(k);
      end
    end
  end

  assign m_axis_tvalid = (g_mask != '0);
  assign m_axis_tdata  = {g_patch[g_idx].yh, g_patch[g_idx].xh,
                          g_patch[g_idx].yl, g_patch[g_idx].xl};
  assign m_axis_tuser  = {g_patch[g_idx].orient, g_patch[g_idx].convex};
  assign m_axis_tlast  = g_single;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_step     <= '0;
      vertex_count <= '0;
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      g_mask       <= '0;
    end else begin
      if (cfg_we) begin
        min_step <= cfg_wdata;
      end

      if (s_fire) begin
        if (s_axis_tlast) begin
          vertex_count <= '0;
        end else begin
          if (vertex_count == 2'd0) begin
            first_vertex <= vin;
          end
          if (vertex_count == 2'd1) begin
            second_vertex <= vin;
          end
          older_vertex <= newer_vertex;
          newer_vertex <= vin;
          if (vertex_count != 2'd3) begin
            vertex_count <= vertex_count + 2'd1;
          end
        end
      end

      if (a_free) begin
        a_valid <= s_fire;
        if (s_fire) begin
          a_corner <= a_corner_next;
        end
      end

      if (b_free) begin
        b_valid <= a_valid;
        if (a_valid) begin
          b_diff <= b_diff_next;
        end
      end

      if (g_ready) begin
        for (int k = 0; k < NUM_CORNERS; k++) begin
          g_mask[k]  <= b_valid && c_res[k].hit;
          g_patch[k] <= c_res[k].patch;
        end
      end else if (m_axis_tready) begin
        g_mask <= g_mask & ~g_sel;
      end
    end
  end

endmodule

`default_nettype wire

### tb/min_step_jog_patcher_test.sv
// Self-checking regression for min_step_jog_patcher: rectilinear rings, broken rings and
// short rings are streamed in under several min_step settings and idling patterns.
// Depends on msjp_pkg and min_step_jog_patcher.
module min_step_jog_patcher_test;
  import msjp_pkg::*;

  localparam longint CMAX = 64'sd1073741823;
  localparam longint CMIN = -64'sd1073741824;
  localparam longint BASE_SPAN = 64'sd1040187392;  // keeps ring walks clear of the range edges
  localparam longint MS_MAX = 64'sd1048575;

  typedef struct {
    longint x;
    longint y;
  } pt_t;

  typedef struct {
    box_t       xl;
    box_t       yl;
    box_t       xh;
    box_t       yh;
    logic       convex;
    logic [1:0] orient;
    logic       last;
  } jog_patch_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [MIN_STEP_W-1:0] cfg_wdata;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  m_axis_tlast;

  // Mirror of the block's ring window and register.
  pt_t    ring_first;
  pt_t    ring_second;
  pt_t    win_older;
  pt_t    win_newer;
  int     ring_count;
  longint jog_min_step;

  jog_patch_t vertex_patches[$];
  jog_patch_t pending_patches[$];

  int send_idle_pct;
  int sink_stall_pct;
  int mismatches;
  int vertices_sent;
  int patches_seen;
  int settings_used;

  min_step_jog_patcher dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("min_step_jog_patcher regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Checks one corner; a hit goes onto the list of patches for the current vertex.
  function automatic void add_jog(input pt_t p0, input pt_t p1, input pt_t p2);
    longint ax, ay, bx, by, xl, yl, xh, yh;
    logic [1:0] orient;
    bit hit, convex;
    jog_patch_t p;
    ax = p1.x - p0.x;
    ay = p1.y - p0.y;
    bx = p2.x - p1.x;
    by = p2.y - p1.y;
    hit = 1'b1;
    convex = 1'b0;
    orient = ORIENT_NE;
    if ((ax < 0 ? -ax : ax) + (ay < 0 ? -ay : ay) >= jog_min_step ||
        (bx < 0 ? -bx : bx) + (by < 0 ? -by : by) >= jog_min_step)
      return;
    if (ax > 0 && ay == 0 && bx == 0 && by < 0) begin
      orient = ORIENT_NE; convex = 1'b1;
    end else if (ax == 0 && ay < 0 && bx < 0 && by == 0) begin
      orient = ORIENT_SE; convex = 1'b1;
    end else if (ax < 0 && ay == 0 && bx == 0 && by > 0) begin
      orient = ORIENT_SW; convex = 1'b1;
    end else if (ax == 0 && ay > 0 && bx > 0 && by == 0) begin
      orient = ORIENT_NW; convex = 1'b1;
    end else if (ax == 0 && ay < 0 && bx > 0 && by == 0) begin
      orient = ORIENT_NE;
    end else if (ax > 0 && ay == 0 && bx == 0 && by > 0) begin
      orient = ORIENT_NW;
    end else if (ax == 0 && ay > 0 && bx < 0 && by == 0) begin
      orient = ORIENT_SW;
    end else if (ax < 0 && ay == 0 && bx == 0 && by < 0) begin
      orient = ORIENT_SE;
    end else begin
      hit = 1'b0;
    end
    if (!hit)
      return;
    xl = p0.x < p1.x ? p0.x : p1.x;
    xl = xl < p2.x ? xl : p2.x;
    yl = p0.y < p1.y ? p0.y : p1.y;
    yl = yl < p2.y ? yl : p2.y;
    xh = p0.x > p1.x ? p0.x : p1.x;
    xh = xh > p2.x ? xh : p2.x;
    yh = p0.y > p1.y ? p0.y : p1.y;
    yh = yh > p2.y ? yh : p2.y;
    // A convex jog is filled out by a full step upwards or downwards.
    if (convex) begin
      if (orient == ORIENT_NE || orient == ORIENT_NW)
        yh = yh + jog_min_step;
      else
        yl = yl - jog_min_step;
    end
    p.xl = xl[BOX_W-1:0];
    p.yl = yl[BOX_W-1:0];
    p.xh = xh[BOX_W-1:0];
    p.yh = yh[BOX_W-1:0];
    p.convex = convex;
    p.orient = orient;
    p.last = 1'b0;
    vertex_patches.push_back(p);
  endfunction

  // Works out the patches that one accepted vertex causes, in output order.
  function automatic void predict_patches(input pt_t v, input bit ring_end);
    vertex_patches = {};
    if (ring_count >= 2)
      add_jog(win_older, win_newer, v);
    if (ring_end) begin
      if (ring_count >= 2) begin
        add_jog(win_newer, v, ring_first);
        add_jog(v, ring_first, ring_second);
      end
      ring_count = 0;
    end else begin
      if (ring_count == 0)
        ring_first = v;
      else if (ring_count == 1)
        ring_second = v;
      win_older = win_newer;
      win_newer = v;
      if (ring_count < 3)
        ring_count++;
    end
    if (vertex_patches.size() > 0)
      vertex_patches[$].last = 1'b1;
    foreach (vertex_patches[i])
      pending_patches.push_back(vertex_patches[i]);
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_vertex(input longint x, input longint y, input bit ring_end);
    coord_t cx, cy;
    pt_t v;
    cx = x[COORD_WIDTH-1:0];
    cy = y[COORD_WIDTH-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_DATA_W - 2 * COORD_WIDTH){1'b0}}, cy, cx};
    s_axis_tlast <= ring_end;
    @(posedge clk);
    while (!s_axis_tready)
      @(posedge clk);
    v.x = longint'(cx);
    v.y = longint'(cy);
    predict_patches(v, ring_end);
    vertices_sent++;
    @(negedge clk);
  endtask

  // Lets the block drain completely, including vertices that caused nothing, then writes.
  task automatic write_min_step(input longint value);
    s_axis_tvalid <= 1'b0;
    while (pending_patches.size() > 0)
      @(negedge clk);
    repeat (12) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[MIN_STEP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    jog_min_step = value;
    settings_used++;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct = send_pct;
    sink_stall_pct = stall_pct;
  endtask

  function automatic longint rand_base();
    return longint'($urandom_range(0, 2 * BASE_SPAN)) - BASE_SPAN;
  endfunction

  function automatic longint rand_step();
    longint span, step;
    span = jog_min_step == 0 ? 15 : jog_min_step + jog_min_step / 2;
    step = $urandom_range(9) == 0 ? 0 : longint'($urandom_range(1, span));
    return $urandom_range(1) ? -step : step;
  endfunction

  // Extremes of the coordinate range, both turn senses and the degenerate rings.
  task automatic test_corner_cases();
    set_idling(0, 0);
    // Clockwise square at the top of the range: yh is pushed past the coordinate range.
    send_vertex(CMAX - 7, CMAX, 0);
    send_vertex(CMAX, CMAX, 0);
    send_vertex(CMAX, CMAX - 7, 0);
    send_vertex(CMAX - 7, CMAX - 7, 1);
    // Clockwise square at the bottom of the range.
    send_vertex(CMIN, CMIN, 0);
    send_vertex(CMIN, CMIN + 7, 0);
    send_vertex(CMIN + 7, CMIN + 7, 0);
    send_vertex(CMIN + 7, CMIN, 1);
    // Anticlockwise square, all concave turns.
    send_vertex(-1, -1, 0);
    send_vertex(4, -1, 0);
    send_vertex(4, 4, 0);
    send_vertex(-1, 4, 1);
    // Rings too short to have a corner.
    send_vertex(0, 0, 1);
    send_vertex(10, 0, 0);
    send_vertex(10, 10, 1);
    // Three-vertex ring whose closing edge is diagonal.
    send_vertex(0, 0, 0);
    send_vertex(5, 0, 0);
    send_vertex(5, 5, 1);
    // Zero-length edge.
    send_vertex(0, 0, 0);
    send_vertex(0, 0, 0);
    send_vertex(3, 0, 0);
    send_vertex(3, 3, 1);
    // Diagonal edges.
    send_vertex(0, 0, 0);
    send_vertex(3, 3, 0);
    send_vertex(3, 0, 0);
    send_vertex(0, 0, 1);
  endtask

  // Closed rectilinear rings with random edge lengths around min_step, plus some short rings.
  task automatic test_ring_walks(input int send_pct, input int stall_pct, input int n_items);
    int sent, n;
    longint x0, y0, x, y;
    bit swap;
    sent = 0;
    set_idling(send_pct, stall_pct);
    while (sent < n_items) begin
      if ($urandom_range(7) == 0)
        n = $urandom_range(1, 3);
      else
        n = 2 * $urandom_range(2, 5);
      x0 = rand_base();
      y0 = rand_base();
      x = x0;
      y = y0;
      swap = $urandom_range(1);
      for (int i = 0; i < n; i++) begin
        if (i > 0) begin
          // The last horizontal edge returns to the first x, so the ring closes squarely.
          if (i % 2 == 1)
            x = (i == n - 1 && n % 2 == 0) ? x0 : x + rand_step();
          else
            y = y + rand_step();
        end
        if (swap)
          send_vertex(y, x, i == n - 1);
        else
          send_vertex(x, y, i == n - 1);
      end
      sent += n;
    end
  endtask

  // Loose vertex streams: diagonal and zero-length edges, jumps and rings of any length.
  task automatic test_broken_rings(input int n_items);
    longint x, y;
    set_idling(26, 26);
    x = rand_base();
    y = rand_base();
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(5) == 0) begin
        x = rand_base();
        y = rand_base();
      end else begin
        if ($urandom_range(1))
          x = x + rand_step();
        if ($urandom_range(1))
          y = y + rand_step();
      end
      send_vertex(x, y, $urandom_range(4) == 0);
    end
  endtask

  always @(negedge clk)
    m_axis_tready <= $urandom_range(99) >= sink_stall_pct;

  always @(posedge clk) begin : check_patches
    jog_patch_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      patches_seen++;
      if (pending_patches.size() == 0) begin
        report_mismatch("patch with none expected, xl", $signed(m_axis_tdata[BOX_W-1:0]), 0);
      end else begin
        want = pending_patches.pop_front();
        if ($signed(m_axis_tdata[BOX_W-1:0]) !== want.xl)
          report_mismatch("patch_xl", $signed(m_axis_tdata[BOX_W-1:0]), want.xl);
        if ($signed(m_axis_tdata[2*BOX_W-1:BOX_W]) !== want.yl)
          report_mismatch("patch_yl", $signed(m_axis_tdata[2*BOX_W-1:BOX_W]), want.yl);
        if ($signed(m_axis_tdata[3*BOX_W-1:2*BOX_W]) !== want.xh)
          report_mismatch("patch_xh", $signed(m_axis_tdata[3*BOX_W-1:2*BOX_W]), want.xh);
        if ($signed(m_axis_tdata[4*BOX_W-1:3*BOX_W]) !== want.yh)
          report_mismatch("patch_yh", $signed(m_axis_tdata[4*BOX_W-1:3*BOX_W]), want.yh);
        if (m_axis_tuser[0] !== want.convex)
          report_mismatch("is_convex", m_axis_tuser[0], want.convex);
        if (m_axis_tuser[2:1] !== want.orient)
          report_mismatch("orientation", m_axis_tuser[2:1], want.orient);
        if (m_axis_tlast !== want.last)
          report_mismatch("last_patch", m_axis_tlast, want.last);
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b1;
    ring_count = 0;
    jog_min_step = 0;
    send_idle_pct = 0;
    sink_stall_pct = 0;
    mismatches = 0;
    vertices_sent = 0;
    patches_seen = 0;
    settings_used = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_min_step(MS_MAX);
    test_corner_cases();
    // Zero turns detection off, and a step of one only passes zero-length edges.
    write_min_step(0);
    test_ring_walks(0, 0, 30);
    write_min_step(1);
    test_ring_walks(0, 0, 20);
    write_min_step(200);
    test_ring_walks(0, 0, 100);
    write_min_step($urandom_range(2, 5000));
    test_ring_walks(83, 0, 100);
    write_min_step(MS_MAX);
    test_ring_walks(0, 83, 100);
    write_min_step($urandom_range(2, 100000));
    test_ring_walks(26, 26, 100);
    write_min_step($urandom_range(2, 5000));
    test_broken_rings(60);

    s_axis_tvalid <= 1'b0;
    while (pending_patches.size() > 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Streamed %0d vertices under %0d min_step settings and four idling patterns,",
             vertices_sent, settings_used);
    $display("checking %0d patches field by field; %0d mismatches.", patches_seen, mismatches);
    if (mismatches == 0)
      $display("min_step_jog_patcher regression: pass");
    else
      $display("min_step_jog_patcher regression: fail");
    $finish;
  end

endmodule

### min_step_jog_patcher.f
src/msjp_pkg.sv
src/min_step_jog_patcher.sv
tb/min_step_jog_patcher_test.sv
